// ===== src/fpsc_pkg.sv =====
// Package: shared types, codes and widths of the passive-serial configuration controller.
package fpsc_pkg;

  // Width of the hold timer and poll counter.
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned REG_W     = 16;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned BEAT_W    = $clog2(2 * BYTE_W);

  localparam logic [CNT_W-1:0]  CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [BEAT_W-1:0] BEAT_LAST = BEAT_W'(2 * BYTE_W - 1);

  typedef enum logic [2:0] {
    REQ_TICK   = 3'd0,
    REQ_DATA   = 3'd1,
    REQ_START  = 3'd2,
    REQ_FINISH = 3'd3,
    REQ_ABORT  = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    ST_NONE   = 2'd0,
    ST_OK     = 2'd1,
    ST_NST_TO = 2'd2,
    ST_CD_TO  = 2'd3
  } stat_e;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_INIT_HIGH = 4'd1,
    PH_INIT_LOW  = 4'd2,
    PH_NST_LOW   = 4'd3,
    PH_CD_LOW    = 4'd4,
    PH_NST_HIGH  = 4'd5,
    PH_FIN_CD    = 4'd6,
    PH_FIN_HOLD  = 4'd7,
    PH_ABORT     = 4'd8
  } phase_e;

  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_TICKS    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_END_HOLD_TICKS = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_POLL_LIMIT     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_USE_CONF_DONE  = CFG_IDX_W'(3);

  typedef struct packed {
    logic [REG_W-1:0] pulse_ticks;
    logic [REG_W-1:0] end_hold_ticks;
    logic [REG_W-1:0] poll_limit;
    logic             use_conf_done;
  } cfg_t;

  typedef struct packed {
    logic  dclk_out;
    logic  data_out;
    logic  nconfig_out;
    logic  busy_res;
    stat_e status;
    logic  last;
  } res_t;

endpackage

// ===== src/fpsc_ifs.sv =====
// Interfaces: request, result and configuration channels.
interface fpsc_req_if import fpsc_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [2:0]        req_type;
  logic [BYTE_W-1:0] data_byte;
  logic              nstatus_in;
  logic              conf_done_in;

  modport source (output valid, req_type, data_byte, nstatus_in, conf_done_in, input ready);
  modport sink   (input valid, req_type, data_byte, nstatus_in, conf_done_in, output ready);
endinterface

interface fpsc_res_if;
  logic       valid;
  logic       ready;
  logic       dclk_out;
  logic       data_out;
  logic       nconfig_out;
  logic       busy_res;
  logic [1:0] status;
  logic       last;

  modport source (output valid, dclk_out, data_out, nconfig_out, busy_res, status, last,
                  input ready);
  modport sink   (input valid, dclk_out, data_out, nconfig_out, busy_res, status, last,
                  output ready);
endinterface

interface fpsc_cfg_if import fpsc_pkg::*; ;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [REG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/fpga_passive_serial_config_top.sv =====
// Top level of the FPGA passive-serial configuration controller.
//
//   channel | dir | fields                                          | accepted when
//   req_i   | in  | req_type, data_byte, nstatus_in, conf_done_in   | valid && ready
//   res_o   | out | dclk_out, data_out, nconfig_out, busy_res,      | valid && ready
//           |     | status, last                                    |
//   cfg_i   | in  | index (register number), data                   | valid && ready
//
// Ticks and commands give one result each; a data byte gives sixteen beats,
// one pin state per cycle unless the output stalls, set by the core's byte shifter.
// Every result is registered into a two-entry output register on acceptance.
// Reset (rst_ni low, async) idles the sequencer, raises nCONFIG, lowers DCLK and
// DATA and loads the register defaults. A stalled output holds the core: once
// both result entries are full, no item and no byte beat advances.
module fpga_passive_serial_config_top import fpsc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  fpsc_req_if.sink   req_i,
  fpsc_res_if.source res_o,
  fpsc_cfg_if.sink   cfg_i
);

  cfg_t cfg;
  res_t core_res;
  res_t out_res;
  logic core_valid;
  logic core_ready;
  logic byte_active;

  // Hold the register values that the sequencer reads.
  fpsc_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .wr_ready_o (cfg_i.ready),
    .cfg_o      (cfg)
  );

  // Advance phases, counters and the byte shifter; build one result per cycle while the result register has room.
  fpsc_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .req_valid_i   (req_i.valid),
    .req_ready_o   (req_i.ready),
    .req_type_i    (req_i.req_type),
    .data_byte_i   (req_i.data_byte),
    .nstatus_i     (req_i.nstatus_in),
    .conf_done_i   (req_i.conf_done_in),
    .res_valid_o   (core_valid),
    .res_ready_i   (core_ready),
    .res_o         (core_res),
    .byte_active_o (byte_active)
  );

  // Register results so the next item can enter while one waits downstream.
  fpsc_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (core_valid),
    .in_ready_o  (core_ready),
    .in_data_i   (core_res),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .out_data_o  (out_res)
  );

  assign res_o.dclk_out    = out_res.dclk_out;
  assign res_o.data_out    = out_res.data_out;
  assign res_o.nconfig_out = out_res.nconfig_out;
  assign res_o.busy_res    = out_res.busy_res;
  assign res_o.status      = out_res.status;
  assign res_o.last        = out_res.last;

  // An item is taken only when its result has room.
  a_req_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> core_ready)
    else $error("input ready without result space");

  // A non-final beat that was stored is followed by more beats of the same byte.
  a_byte_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (core_valid && core_ready && !core_res.last) |=> (byte_active && !req_i.ready))
    else $error("byte burst cut short");

  // Only the final result of an item carries a status event.
  a_status_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (core_valid && core_ready && (core_res.status != ST_NONE)) |-> core_res.last)
    else $error("status reported on a non-final result");

endmodule

// ===== src/fpsc_cfg_regs.sv =====
// Configuration register file of the passive-serial configuration controller.
module fpsc_cfg_regs import fpsc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_valid_i,
  input  logic [CFG_IDX_W-1:0] wr_index_i,
  input  logic [REG_W-1:0]     wr_data_i,
  output logic                 wr_ready_o,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign wr_ready_o = 1'b1;
  assign cfg_o      = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_valid_i) begin
      case (wr_index_i)
        CFG_PULSE_TICKS:    cfg_d.pulse_ticks    = wr_data_i;
        CFG_END_HOLD_TICKS: cfg_d.end_hold_ticks = wr_data_i;
        CFG_POLL_LIMIT:     cfg_d.poll_limit     = wr_data_i;
        CFG_USE_CONF_DONE:  cfg_d.use_conf_done  = wr_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse_ticks    <= REG_W'(1000);
      cfg_q.end_hold_ticks <= REG_W'(100);
      cfg_q.poll_limit     <= {REG_W{1'b1}};
      cfg_q.use_conf_done  <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== src/fpsc_core.sv =====
// Sequencer core: phase state machine, hold/poll counters and byte shifter.
module fpsc_core import fpsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  logic [2:0]        req_type_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic              nstatus_i,
  input  logic              conf_done_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output res_t              res_o,
  output logic              byte_active_o
);

  phase_e            phase_q, phase_d;
  logic [CNT_W-1:0]  hold_q, hold_d;
  logic [CNT_W-1:0]  poll_q, poll_d;
  logic              ncfg_q, ncfg_d;
  logic              dclk_q, dclk_d;
  logic              data_q, data_d;
  logic              byte_active_q, byte_active_d;
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic [BEAT_W-1:0] beat_q, beat_d;

  logic             accept;
  logic             hold_end;
  logic [CNT_W-1:0] hold_dec;
  logic [CNT_W-1:0] lim_ld;
  logic [CNT_W-1:0] lim;
  logic [CNT_W-1:0] poll_inc;
  logic             poll_exp;
  stat_e            st;
  logic             last;

  // Load a register value into a counter, clamped at the counter maximum.
  function automatic logic [CNT_W-1:0] sat_load(input logic [REG_W-1:0] v);
    if ((v >> CNT_W) != '0) begin
      return CNT_MAX;
    end
    return CNT_W'(v);
  endfunction

  assign req_ready_o   = res_ready_i && !byte_active_q;
  assign accept        = req_valid_i && req_ready_o;
  assign res_valid_o   = byte_active_q || req_valid_i;
  assign byte_active_o = byte_active_q;

  assign hold_end = (hold_q <= CNT_W'(1));
  assign hold_dec = hold_end ? '0 : hold_q - CNT_W'(1);
  assign lim_ld   = sat_load(cfg_i.poll_limit);
  assign lim      = (lim_ld == '0) ? CNT_W'(1) : lim_ld;
  assign poll_inc = (poll_q < CNT_MAX) ? poll_q + CNT_W'(1) : poll_q;
  assign poll_exp = (poll_inc >= lim);

  always_comb begin
    phase_d       = phase_q;
    hold_d        = hold_q;
    poll_d        = poll_q;
    ncfg_d        = ncfg_q;
    dclk_d        = dclk_q;
    data_d        = data_q;
    byte_active_d = byte_active_q;
    byte_d        = byte_q;
    beat_d        = beat_q;
    st            = ST_NONE;
    last          = 1'b1;

    if (byte_active_q) begin
      // Shift the remaining beats of the held byte, one per cycle while the output has room.
      if (res_ready_i) begin
        data_d = byte_q[beat_q[BEAT_W-1:1]];
        dclk_d = ~beat_q[0];
        beat_d = beat_q + BEAT_W'(1);
        last   = (beat_q == BEAT_LAST);
        if (beat_q == BEAT_LAST) begin
          byte_active_d = 1'b0;
        end
      end
    end else if (accept) begin
      case (req_type_i)
        REQ_TICK: begin
          case (phase_q)
            PH_INIT_HIGH: begin
              hold_d = hold_dec;
              if (hold_end) begin
                ncfg_d  = 1'b0;
                hold_d  = sat_load(cfg_i.pulse_ticks);
                phase_d = PH_INIT_LOW;
              end
            end
            PH_INIT_LOW: begin
              hold_d = hold_dec;
              if (hold_end) begin
                phase_d = PH_NST_LOW;
                poll_d  = '0;
              end
            end
            PH_NST_LOW: begin
              if (!nstatus_i) begin
                poll_d = '0;
                if (cfg_i.use_conf_done) begin
                  phase_d = PH_CD_LOW;
                end else begin
                  ncfg_d  = 1'b1;
                  phase_d = PH_NST_HIGH;
                end
              end else begin
                poll_d = poll_inc;
                if (poll_exp) begin
                  phase_d = PH_IDLE;
                  st      = ST_NST_TO;
                end
              end
            end
            PH_CD_LOW: begin
              if (!conf_done_i) begin
                ncfg_d  = 1'b1;
                poll_d  = '0;
                phase_d = PH_NST_HIGH;
              end else begin
                poll_d = poll_inc;
                if (poll_exp) begin
                  phase_d = PH_IDLE;
                  st      = ST_CD_TO;
                end
              end
            end
            PH_NST_HIGH: begin
              if (nstatus_i) begin
                phase_d = PH_IDLE;
                st      = ST_OK;
              end else begin
                poll_d = poll_inc;
                if (poll_exp) begin
                  phase_d = PH_IDLE;
                  st      = ST_NST_TO;
                end
              end
            end
            PH_FIN_CD: begin
              if (conf_done_i) begin
                phase_d = PH_FIN_HOLD;
                hold_d  = sat_load(cfg_i.end_hold_ticks);
              end else begin
                poll_d = poll_inc;
                if (poll_exp) begin
                  phase_d = PH_IDLE;
                  st      = ST_CD_TO;
                end
              end
            end
            PH_FIN_HOLD: begin
              hold_d = hold_dec;
              if (hold_end) begin
                phase_d = PH_IDLE;
                st      = ST_OK;
              end
            end
            PH_ABORT: begin
              hold_d = hold_dec;
              if (hold_end) begin
                ncfg_d  = 1'b1;
                phase_d = PH_IDLE;
                st      = ST_OK;
              end
            end
            default: phase_d = PH_IDLE;
          endcase
        end
        REQ_DATA: begin
          // Emit the first beat now and keep the byte for the other fifteen.
          data_d        = data_byte_i[0];
          dclk_d        = 1'b1;
          byte_d        = data_byte_i;
          beat_d        = BEAT_W'(1);
          byte_active_d = 1'b1;
          last          = 1'b0;
        end
        REQ_START: begin
          dclk_d  = 1'b0;
          ncfg_d  = 1'b1;
          hold_d  = sat_load(cfg_i.pulse_ticks);
          phase_d = PH_INIT_HIGH;
        end
        REQ_FINISH: begin
          if (phase_q == PH_IDLE) begin
            if (cfg_i.use_conf_done) begin
              phase_d = PH_FIN_CD;
              poll_d  = '0;
            end else begin
              phase_d = PH_FIN_HOLD;
              hold_d  = sat_load(cfg_i.end_hold_ticks);
            end
          end
        end
        REQ_ABORT: begin
          ncfg_d  = 1'b0;
          hold_d  = sat_load(cfg_i.pulse_ticks);
          phase_d = PH_ABORT;
        end
        default: ;
      endcase
    end

    res_o.dclk_out    = dclk_d;
    res_o.data_out    = data_d;
    res_o.nconfig_out = ncfg_d;
    res_o.busy_res    = (phase_d != PH_IDLE);
    res_o.status      = st;
    res_o.last        = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      hold_q        <= '0;
      poll_q        <= '0;
      ncfg_q        <= 1'b1;
      dclk_q        <= 1'b0;
      data_q        <= 1'b0;
      byte_active_q <= 1'b0;
      beat_q        <= '0;
    end else begin
      phase_q       <= phase_d;
      hold_q        <= hold_d;
      poll_q        <= poll_d;
      ncfg_q        <= ncfg_d;
      dclk_q        <= dclk_d;
      data_q        <= data_d;
      byte_active_q <= byte_active_d;
      beat_q        <= beat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

endmodule

// ===== src/fpsc_skid.sv =====
// Two-entry result register that decouples the core from output backpressure.
module fpsc_skid import fpsc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  res_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_data_o
);

  logic main_valid_q, main_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t main_q, main_d;
  res_t skid_q, skid_d;
  logic push, pop;

  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = main_valid_q && out_ready_i;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_q || pop) begin
        main_d       = in_data_i;
        main_valid_d = 1'b1;
      end else begin
        skid_d       = in_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      main_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule
